FILE: rtl/core/nfa_pkg.sv
package nfa_pkg;

    // The used-bit map is stored as 64-bit words.
    localparam int WORD_W     = 64;
    localparam int WORD_SHIFT = 6;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE  = 2'd2;

    // Position of the lowest set bit of a map word.
    function automatic logic [WORD_SHIFT-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [WORD_SHIFT-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = WORD_SHIFT'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: rtl/core/nfa_map_ram.sv
module nfa_map_ram
    import nfa_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/next_fit_id_allocator_core.sv
// Next-fit identifier allocator. One used bit per identifier lives in a
// single-port-write, registered-read memory of 64-bit words. After reset the
// block runs a clearing pass over all ceil(ID_SPACE/64) map words (16 at
// the default size) before it takes its first item; configuration writes
// are taken throughout. An allocate reads the map one word per cycle within
// each pass, starting at the word of the next-candidate pointer, and scans
// at most ceil(ID_SPACE/64) + 1 words. A scan that wraps to the wrap target
// restarts its reads at the word of the wrap target. Lookup and free read
// one word. A finished result waits in the output register while the next
// item is already being processed.
module next_fit_id_allocator_core
    import nfa_pkg::*;
#(
    parameter int ID_SPACE = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [9:0] i_target_id,

    output logic       o_valid,
    input  logic       i_ready,
    output logic [9:0] o_result_id,
    output logic [1:0] o_status,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_first_dynamic_id
);

    localparam int MAP_WORDS = (ID_SPACE + WORD_W - 1) / WORD_W;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int ID_W      = $clog2(ID_SPACE);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [9:0]        r_fdi;
    logic [ID_W-1:0]   r_next, n_next;
    logic [WA_W-1:0]   r_clr, n_clr;
    logic [1:0]        r_op, n_op;
    logic [9:0]        r_tgt, n_tgt;
    logic [WA_W-1:0]   r_rd_w, n_rd_w;
    logic [WA_W-1:0]   r_dw, n_dw;
    logic              r_dv, n_dv;
    logic              r_iss_done, n_iss_done;
    logic              r_phase_b, n_phase_b;
    logic              r_two, n_two;
    logic [WA_W-1:0]   r_first_w, n_first_w;
    logic [WA_W-1:0]   r_last_w, n_last_w;
    logic [WORD_W-1:0] r_lo_mask, n_lo_mask;
    logic [WORD_W-1:0] r_hi_mask, n_hi_mask;
    logic [9:0]        r_res_id, n_res_id;
    logic [1:0]        r_res_st, n_res_st;
    logic              r_out_valid;
    logic [9:0]        r_out_id;
    logic [1:0]        r_out_st;

    logic              mem_we;
    logic [WA_W-1:0]   mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WA_W-1:0]   mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic [ID_W-1:0]   wt;
    logic              setup_b;
    logic [31:0]       lo32;
    logic [31:0]       hi_last32;
    logic [WA_W-1:0]   su_first_w;
    logic [WA_W-1:0]   su_last_w;
    logic [WORD_W-1:0] su_lo_mask;
    logic [WORD_W-1:0] su_hi_mask;
    logic [WORD_W-1:0] scan_mask;
    logic [WORD_W-1:0] free_bits;
    logic [31:0]       found32;
    logic [WA_W-1:0]   tgt_word;
    logic [WA_W-1:0]   in_word;
    logic              tgt_hit;
    logic              out_load;

    nfa_map_ram #(
        .DEPTH(MAP_WORDS),
        .AW   (WA_W)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Wrap target: an out-of-range first dynamic identifier wraps to zero.
    assign wt = (32'(r_fdi) < 32'(ID_SPACE)) ? ID_W'(32'(r_fdi)) : '0;

    // Scan range setup. The first pass covers [pointer, ID_SPACE); when the
    // pointer is above the wrap target a second pass covers [wrap, pointer).
    assign setup_b    = (r_state == S_SCAN);
    assign lo32       = setup_b ? 32'(wt) : 32'(r_next);
    assign hi_last32  = setup_b ? (32'(r_next) - 32'd1) : 32'(ID_SPACE - 1);
    assign su_first_w = WA_W'(lo32 >> WORD_SHIFT);
    assign su_last_w  = WA_W'(hi_last32 >> WORD_SHIFT);
    assign su_lo_mask = {WORD_W{1'b1}} << lo32[WORD_SHIFT-1:0];
    assign su_hi_mask = {WORD_W{1'b1}} >>
                        (WORD_SHIFT'(WORD_W - 1) - hi_last32[WORD_SHIFT-1:0]);

    assign scan_mask = ((r_dw == r_first_w) ? r_lo_mask : {WORD_W{1'b1}}) &
                       ((r_dw == r_last_w) ? r_hi_mask : {WORD_W{1'b1}});
    assign free_bits = ~mem_rdata & scan_mask;
    assign found32   = (32'(r_dw) << WORD_SHIFT) | 32'(first_set(free_bits));

    assign tgt_word  = WA_W'(32'(r_tgt) >> WORD_SHIFT);
    assign in_word   = WA_W'(32'(i_target_id) >> WORD_SHIFT);
    assign tgt_hit   = mem_rdata[r_tgt[WORD_SHIFT-1:0]];
    assign mem_raddr = (r_state == S_IDLE) ? in_word : r_rd_w;

    assign out_load  = (r_state == S_RESP) && (!r_out_valid || i_ready);

    always_comb begin
        n_state    = r_state;
        n_next     = r_next;
        n_clr      = r_clr;
        n_op       = r_op;
        n_tgt      = r_tgt;
        n_rd_w     = r_rd_w;
        n_dw       = r_dw;
        n_dv       = r_dv;
        n_iss_done = r_iss_done;
        n_phase_b  = r_phase_b;
        n_two      = r_two;
        n_first_w  = r_first_w;
        n_last_w   = r_last_w;
        n_lo_mask  = r_lo_mask;
        n_hi_mask  = r_hi_mask;
        n_res_id   = r_res_id;
        n_res_st   = r_res_st;
        mem_we     = 1'b0;
        mem_waddr  = r_clr;
        mem_wdata  = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == WA_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op  = i_opcode;
                    n_tgt = i_target_id;
                    if (i_opcode == OP_ALLOC) begin
                        n_first_w  = su_first_w;
                        n_last_w   = su_last_w;
                        n_lo_mask  = su_lo_mask;
                        n_hi_mask  = su_hi_mask;
                        n_rd_w     = su_first_w;
                        n_iss_done = 1'b0;
                        n_dv       = 1'b0;
                        n_phase_b  = 1'b0;
                        n_two      = (r_next > wt);
                        n_state    = S_SCAN;
                    end else if (32'(i_target_id) >= 32'(ID_SPACE)) begin
                        n_res_id = i_target_id;
                        n_res_st = ST_NOT_IN_USE;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_SCAN: begin
                // Stream one word read per cycle; the registered read returns the data in the next cycle.
                if (!r_iss_done) begin
                    n_dv = 1'b1;
                    n_dw = r_rd_w;
                    if (r_rd_w == r_last_w) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_rd_w = r_rd_w + 1'b1;
                    end
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (|free_bits) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_dw;
                        mem_wdata = mem_rdata |
                                    ({{(WORD_W-1){1'b0}}, 1'b1} << first_set(free_bits));
                        n_res_id  = found32[9:0];
                        n_res_st  = ST_OK;
                        if (found32 == 32'(ID_SPACE - 1)) begin
                            n_next = wt;
                        end else begin
                            n_next = ID_W'(found32 + 32'd1);
                        end
                        n_state = S_RESP;
                    end else if (r_dw == r_last_w) begin
                        if (!r_phase_b && r_two) begin
                            n_phase_b  = 1'b1;
                            n_first_w  = su_first_w;
                            n_last_w   = su_last_w;
                            n_lo_mask  = su_lo_mask;
                            n_hi_mask  = su_hi_mask;
                            n_rd_w     = su_first_w;
                            n_iss_done = 1'b0;
                            n_dv       = 1'b0;
                        end else begin
                            n_res_id = '0;
                            n_res_st = ST_EXHAUSTED;
                            n_state  = S_RESP;
                        end
                    end
                end
            end
            S_CHECK: begin
                n_res_id = r_tgt;
                if (tgt_hit) begin
                    n_res_st = ST_OK;
                    if (r_op == OP_FREE) begin
                        mem_we    = 1'b1;
                        mem_waddr = tgt_word;
                        mem_wdata = mem_rdata &
                                    ~({{(WORD_W-1){1'b0}}, 1'b1} << r_tgt[WORD_SHIFT-1:0]);
                    end
                end else begin
                    n_res_st = ST_NOT_IN_USE;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_next     <= ID_W'(1);
            r_clr      <= '0;
            r_dv       <= 1'b0;
            r_iss_done <= 1'b0;
            r_phase_b  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_next     <= n_next;
            r_clr      <= n_clr;
            r_dv       <= n_dv;
            r_iss_done <= n_iss_done;
            r_phase_b  <= n_phase_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_tgt     <= n_tgt;
        r_rd_w    <= n_rd_w;
        r_dw      <= n_dw;
        r_two     <= n_two;
        r_first_w <= n_first_w;
        r_last_w  <= n_last_w;
        r_lo_mask <= n_lo_mask;
        r_hi_mask <= n_hi_mask;
        r_res_id  <= n_res_id;
        r_res_st  <= n_res_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdi <= 10'd1;
        end else if (i_cfg_valid) begin
            r_fdi <= i_cfg_first_dynamic_id;
        end
    end

    // Output register: a result waits here until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id <= r_res_id;
            r_out_st <= r_res_st;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result_id = r_out_id;
    assign o_status    = r_out_st;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: verif/tb_next_fit_id_allocator_core.sv
module tb_next_fit_id_allocator_core
    import nfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_SPACE    = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 30;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] tgt;
    } t_request;

    typedef struct packed {
        logic [9:0] id;
        logic [1:0] status;
    } t_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] in_op = OP_LOOKUP;
    logic [9:0] in_tgt = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [9:0] cfg_data = '0;
    logic       o_ready;
    logic       o_valid;
    logic [9:0] o_result_id;
    logic [1:0] o_status;
    logic       o_cfg_ready;

    // Shadow state of the allocator, updated at each accepted transfer.
    bit          id_used [ID_SPACE];
    int unsigned next_ptr = 1;
    int unsigned wrap_id = 1;

    t_request op_queue[$];
    t_reply   predicted_replies[$];

    int errors = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int n_granted = 0, n_exhausted = 0, n_freed = 0, n_absent = 0, n_cfg = 0;

    next_fit_id_allocator_core #(.ID_SPACE(ID_SPACE)) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (in_valid),
        .o_ready               (o_ready),
        .i_opcode              (in_op),
        .i_target_id           (in_tgt),
        .o_valid               (o_valid),
        .i_ready               (out_ready),
        .o_result_id           (o_result_id),
        .o_status              (o_status),
        .i_cfg_valid           (cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_first_dynamic_id(cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30) begin
            $display("ERROR at %0t ns: %s", $realtime, msg);
        end
    endtask

    // Next-fit scan over the shadow map; exhaustion leaves the pointer alone.
    task automatic apply_request(input logic [1:0] op, input logic [9:0] tgt,
                                 output t_reply r);
        int unsigned wt, saved, start, cand;
        bit found;
        r.id = tgt;
        r.status = ST_OK;
        if (op == OP_ALLOC) begin
            wt = (wrap_id < ID_SPACE) ? wrap_id : 0;
            saved = next_ptr;
            if (next_ptr >= ID_SPACE) next_ptr = wt;
            start = next_ptr;
            found = 1'b0;
            for (int n = 0; n < ID_SPACE; n++) begin
                cand = next_ptr;
                next_ptr = (next_ptr == ID_SPACE - 1) ? wt : next_ptr + 1;
                if (!id_used[cand]) begin
                    id_used[cand] = 1'b1;
                    r.id = 10'(cand);
                    found = 1'b1;
                    break;
                end
                if (next_ptr == start) break;
            end
            if (!found) begin
                next_ptr = saved;
                r.id = '0;
                r.status = ST_EXHAUSTED;
            end
        end else if (op == OP_FREE) begin
            if (id_used[tgt]) id_used[tgt] = 1'b0;
            else r.status = ST_NOT_IN_USE;
        end else if (!id_used[tgt]) begin
            r.status = ST_NOT_IN_USE;
        end
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver: holds the head of the queue until its transfer completes.
    always @(posedge i_clk) begin
        t_reply r;
        bit send;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            send = in_valid;
            if (in_valid && o_ready) begin
                apply_request(in_op, in_tgt, r);
                predicted_replies.push_back(r);
                if (in_op == OP_ALLOC && r.status == ST_OK) n_granted++;
                if (r.status == ST_EXHAUSTED) n_exhausted++;
                if (r.status == ST_NOT_IN_USE) n_absent++;
                if (in_op == OP_FREE && r.status == ST_OK) n_freed++;
                void'(op_queue.pop_front());
                send = 1'b0;
                if ($urandom_range(0, 99) < 3) send_calm = ~send_calm;
                send_gap = pick_gap(send_calm);
            end
            if (!send) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (op_queue.size() > 0) begin
                    in_op <= op_queue[0].op;
                    in_tgt <= op_queue[0].tgt;
                    send = 1'b1;
                end
            end
            in_valid <= send;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_valid && out_ready) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected result id %0d status %0d",
                                              o_result_id, o_status));
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_result_id !== want.id)
                        report_mismatch($sformatf("result_id %0d, expected %0d",
                                                  o_result_id, want.id));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d (id %0d)",
                                                  o_status, want.status, want.id));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 2) recv_calm = ~recv_calm;
                if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL next_fit_id_allocator_core");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] op, input logic [9:0] tgt);
        t_request q;
        q.op = op;
        q.tgt = tgt;
        op_queue.push_back(q);
    endtask

    task automatic wait_idle();
        while (op_queue.size() > 0 || predicted_replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_first_dynamic(input logic [9:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        wrap_id = v;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Mostly targets identifiers that are currently held, so frees succeed.
    function automatic logic [9:0] pick_target();
        int sel, start;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            start = $urandom_range(0, ID_SPACE - 1);
            for (int k = 0; k < ID_SPACE; k++) begin
                if (id_used[(start + k) % ID_SPACE]) return 10'((start + k) % ID_SPACE);
            end
        end
        if (sel == 8) return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
        if (sel == 9) return 10'(wrap_id);
        return 10'($urandom_range(0, ID_SPACE - 1));
    endfunction

    task automatic run_mix(input int count, input int alloc_pct, input int free_pct,
                           input int lookup_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            while (op_queue.size() >= 4) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                queue_request(OP_ALLOC, 10'($urandom_range(0, ID_SPACE - 1)));
            else if (r < alloc_pct + free_pct)
                queue_request(OP_FREE, pick_target());
            else if (r < alloc_pct + free_pct + lookup_pct)
                queue_request(OP_LOOKUP, pick_target());
            else
                queue_request(OP_SPARE, pick_target());
        end
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map, reset wrap target: absent ids, first grants, double free,
        // the spare opcode, and an allocate whose target field must be ignored.
        queue_request(OP_LOOKUP, 10'd0);
        queue_request(OP_LOOKUP, 10'd1023);
        queue_request(OP_FREE, 10'd1023);
        queue_request(OP_FREE, 10'd0);
        queue_request(OP_SPARE, 10'd1023);
        queue_request(OP_ALLOC, 10'd0);
        queue_request(OP_ALLOC, 10'd1023);
        queue_request(OP_LOOKUP, 10'd1);
        queue_request(OP_SPARE, 10'd2);
        queue_request(OP_FREE, 10'd1);
        queue_request(OP_FREE, 10'd1);
        queue_request(OP_LOOKUP, 10'd1);
        queue_request(OP_ALLOC, 10'd512);
        queue_request(OP_FREE, 10'd2);
        queue_request(OP_FREE, 10'd3);
        queue_request(OP_LOOKUP, 10'd3);
        wait_idle();

        // A long allocate-heavy stretch walks the pointer to the top, wraps into
        // a narrow window and runs it dry while low ids stay free.
        set_first_dynamic(10'd960);
        run_mix(1100, 95, 2, 2);
        set_first_dynamic(10'd1023);
        run_mix(140, 60, 25, 10);
        set_first_dynamic(10'd0);
        run_mix(140, 30, 50, 15);
        set_first_dynamic(10'($urandom_range(0, ID_SPACE - 1)));
        run_mix(140, 55, 30, 10);
        set_first_dynamic(10'd1);
        run_mix(140, 70, 15, 10);
        set_first_dynamic(10'($urandom_range(500, ID_SPACE - 1)));
        run_mix(140, 50, 35, 10);

        $display("Covered %0d grants, %0d exhausted allocates, %0d frees, %0d not-in-use replies",
                 n_granted, n_exhausted, n_freed, n_absent);
        $display("across %0d wrap-target settings in %0d cycles", n_cfg + 1, cycles);
        if (errors == 0) begin
            $display("PASS next_fit_id_allocator_core");
        end else begin
            $display("FAIL next_fit_id_allocator_core");
        end
        $finish;
    end

endmodule

FILE: next_fit_id_allocator_core.f
rtl/core/nfa_pkg.sv
rtl/core/nfa_map_ram.sv
rtl/core/next_fit_id_allocator_core.sv
verif/tb_next_fit_id_allocator_core.sv
